// ===== rtl/core/erp_pkg.sv =====
// Package: shared constants, types and the arctangent table for the point rotator.
`default_nettype none
package erp_pkg;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int ADDR_W           = 4;
    localparam logic [ADDR_W-1:0] REG_ALPHA = 4'h0;
    localparam logic [ADDR_W-1:0] REG_THETA = 4'h4;
    localparam logic [ADDR_W-1:0] REG_GAMMA = 4'h8;
    localparam logic [ADDR_W-1:0] REG_MODE  = 4'hC;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sh026DD3B6A;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    function automatic logic signed [35:0] atan_lut(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:  r = 36'sh020000000;
            5'd1:  r = 36'sh012E4051E;
            5'd2:  r = 36'sh009FB385B;
            5'd3:  r = 36'sh0051111D4;
            5'd4:  r = 36'sh0028B0D43;
            5'd5:  r = 36'sh00145D7E1;
            5'd6:  r = 36'sh000A2F61E;
            5'd7:  r = 36'sh000517C55;
            5'd8:  r = 36'sh00028BE53;
            5'd9:  r = 36'sh000145F2F;
            5'd10: r = 36'sh0000A2F98;
            5'd11: r = 36'sh0000517CC;
            5'd12: r = 36'sh000028BE6;
            5'd13: r = 36'sh0000145F3;
            5'd14: r = 36'sh00000A2F9;
            5'd15: r = 36'sh00000517C;
            5'd16: r = 36'sh0000028BE;
            5'd17: r = 36'sh00000145F;
            5'd18: r = 36'sh000000A2F;
            5'd19: r = 36'sh000000517;
            5'd20: r = 36'sh00000028B;
            5'd21: r = 36'sh000000145;
            5'd22: r = 36'sh0000000A2;
            5'd23: r = 36'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/erp_matrix.sv =====
// Matrix builder: CORDIC sine/cosine and sequenced entry products.
`default_nettype none
module erp_matrix #(
    parameter int CORDIC_STEPS = erp_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = erp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [15:0]               alpha,
    input  wire logic [15:0]               theta,
    input  wire logic [15:0]               gamma,
    input  wire logic                      use_gamma,
    output logic                           busy,
    output logic                           done,
    output logic signed [FRAC_BITS+1:0]    m_ent [9]
);
    import erp_pkg::*;
    localparam int EW    = FRAC_BITS + 2;
    localparam int NST   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int SH    = 30 - FRAC_BITS;
    localparam int PW    = 2 * EW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_INIT = 5'b00010, S_ITER = 5'b00100,
        S_OPS  = 5'b01000, S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] ang_idx_reg;
    logic [4:0] it_reg;
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic flip_reg;
    logic signed [EW-1:0] sc_reg [6];   // s0 c0 s1 c1 s2 c2
    logic signed [EW+2:0] t_reg [4];
    logic [3:0] op_reg;
    logic signed [EW-1:0] ent_reg [9];

    logic [15:0] ang, afold;
    logic fl;
    logic signed [35:0] cxf, cyf;
    logic signed [EW-1:0] cr, sr;

    always_comb begin
        case (ang_idx_reg)
            2'd0: ang = alpha;
            2'd1: ang = theta;
            default: ang = gamma;
        endcase
        fl = ang[15] ^ ang[14];
        afold = fl ? (ang + 16'h8000) : ang;
        cxf = flip_reg ? -cx_reg : cx_reg;
        cyf = flip_reg ? -cy_reg : cy_reg;
        cr = EW'((cxf + (36'sd1 <<< (SH - 1))) >>> SH);
        sr = EW'((cyf + (36'sd1 <<< (SH - 1))) >>> SH);
    end

    // product sequencer: one multiply per cycle
    logic signed [EW+2:0] opa, opb;
    logic signed [PW+5:0] prod;
    logic signed [EW+2:0] pr;
    logic signed [EW-1:0] s0, c0, s1, c1, s2, c2;
    assign s0 = sc_reg[0]; assign c0 = sc_reg[1];
    assign s1 = sc_reg[2]; assign c1 = sc_reg[3];
    assign s2 = sc_reg[4]; assign c2 = sc_reg[5];

    function automatic logic signed [EW+2:0] ext(input logic signed [EW-1:0] v);
        return (EW+3)'(v);
    endfunction

    always_comb begin
        opa = '0; opb = '0;
        if (use_gamma) begin
            case (op_reg)
                4'd0:  begin opa = ext(c2); opb = ext(c0); end
                4'd1:  begin opa = ext(s2); opb = ext(c0); end
                4'd2:  begin opa = ext(s1); opb = ext(s0); end
                4'd3:  begin opa = t_reg[0]; opb = ext(c2); end
                4'd4:  begin opa = ext(s2); opb = ext(c1); end
                4'd5:  begin opa = ext(c1); opb = ext(c2); end
                4'd6:  begin opa = ext(s1); opb = ext(s2); end
                4'd7:  begin opa = t_reg[2]; opb = ext(s0); end
                4'd8:  begin opa = ext(s1); opb = ext(c0); end
                4'd9:  begin opa = ext(s0); opb = ext(c1); end
                4'd10: begin opa = t_reg[2]; opb = ext(c2); end
                4'd11: begin opa = ext(s1); opb = ext(c2); end
                4'd12: begin opa = ext(s2); opb = ext(s0); end
                4'd13: begin opa = t_reg[3]; opb = ext(c1); end
                4'd14: begin opa = ext(c1); opb = ext(c0); end
                default: begin opa = '0; opb = '0; end
            endcase
        end else begin
            case (op_reg)
                4'd0: begin opa = ext(s0); opb = ext(s1); end
                4'd1: begin opa = ext(s0); opb = ext(c1); end
                4'd2: begin opa = ext(s1); opb = ext(c0); end
                4'd3: begin opa = ext(c0); opb = ext(c1); end
                default: begin opa = '0; opb = '0; end
            endcase
        end
        prod = (PW+6)'(opa) * (PW+6)'(opb);
        pr = (EW+3)'((prod + ((PW+6)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end

    function automatic logic signed [EW-1:0] sat(input logic signed [EW+3:0] v);
        logic signed [EW+3:0] lim;
        lim = (EW+4)'(1) <<< (FRAC_BITS + 1);
        if (v > lim - 1) return EW'(lim - 1);
        if (v < -lim) return EW'(-lim);
        return EW'(v);
    endfunction

    function automatic logic signed [EW+3:0] w(input logic signed [EW+2:0] v);
        return (EW+4)'(v);
    endfunction

    logic [3:0] last_op;
    assign last_op = use_gamma ? 4'd14 : 4'd3;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start) state_next = S_INIT;
            S_INIT: state_next = S_ITER;
            S_ITER: if (it_reg == 5'(NST)) begin
                if (ang_idx_reg == (use_gamma ? 2'd2 : 2'd1)) state_next = S_OPS;
                else state_next = S_INIT;
            end
            S_OPS:  if (op_reg == last_op) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ang_idx_reg <= '0;
            for (int k = 0; k < 9; k++)
                ent_reg[k] <= (k % 4 == 0) ? (EW'(1) <<< FRAC_BITS) : '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: ang_idx_reg <= '0;
                S_INIT: begin
                    flip_reg <= fl;
                    cx_reg <= CORDIC_GAIN;
                    cy_reg <= '0;
                    cz_reg <= 36'(signed'(afold)) <<< 16;
                    it_reg <= '0;
                    op_reg <= '0;
                end
                S_ITER: begin
                    if (it_reg == 5'(NST)) begin
                        sc_reg[{ang_idx_reg, 1'b0}] <= sr;
                        sc_reg[{ang_idx_reg, 1'b1}] <= cr;
                        ang_idx_reg <= ang_idx_reg + 2'd1;
                    end else begin
                        it_reg <= it_reg + 5'd1;
                        if (!cz_reg[35]) begin
                            cx_reg <= cx_reg - (cy_reg >>> it_reg);
                            cy_reg <= cy_reg + (cx_reg >>> it_reg);
                            cz_reg <= cz_reg - atan_lut(it_reg);
                        end else begin
                            cx_reg <= cx_reg + (cy_reg >>> it_reg);
                            cy_reg <= cy_reg - (cx_reg >>> it_reg);
                            cz_reg <= cz_reg + atan_lut(it_reg);
                        end
                    end
                end
                S_OPS: begin
                    op_reg <= op_reg + 4'd1;
                    if (use_gamma) begin
                        case (op_reg)
                            4'd0:  ent_reg[0] <= sat(w(pr));
                            4'd1:  ent_reg[1] <= sat(-w(pr));
                            4'd2:  t_reg[0] <= pr;
                            4'd3:  t_reg[0] <= pr;
                            4'd4:  ent_reg[3] <= sat(w(t_reg[0]) + w(pr));
                            4'd5:  t_reg[1] <= pr;
                            4'd6:  t_reg[2] <= pr;
                            4'd7:  ent_reg[4] <= sat(w(t_reg[1]) - w(pr));
                            4'd8:  ent_reg[5] <= sat(-w(pr));
                            4'd9:  t_reg[2] <= pr;
                            4'd10: ent_reg[6] <= sat(w(t_reg[3]) - w(pr));
                            4'd11: t_reg[0] <= pr;
                            4'd12: t_reg[3] <= pr;
                            4'd13: ent_reg[7] <= sat(w(t_reg[0]) + w(pr));
                            4'd14: ent_reg[8] <= sat(w(pr));
                            default: ;
                        endcase
                        if (op_reg == 4'd0) ent_reg[2] <= s0;
                        if (op_reg == 4'd6) t_reg[3] <= pr;
                    end else begin
                        case (op_reg)
                            4'd0: begin
                                ent_reg[1] <= sat(w(pr));
                                ent_reg[0] <= c0;
                                ent_reg[3] <= '0;
                                ent_reg[4] <= c1;
                                ent_reg[5] <= sat(-w(ext(s1)));
                                ent_reg[6] <= sat(-w(ext(s0)));
                            end
                            4'd1: ent_reg[2] <= sat(w(pr));
                            4'd2: ent_reg[7] <= sat(w(pr));
                            4'd3: ent_reg[8] <= sat(w(pr));
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    always_comb for (int k = 0; k < 9; k++) m_ent[k] = ent_reg[k];
endmodule
`default_nettype wire

// ===== rtl/core/erp_front.sv =====
// Front end: accepts points and queues them ahead of the multiply-add datapath.
`default_nettype none
module erp_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            hold,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire erp_pkg::point_t s_pt,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output erp_pkg::point_t      q_pt
);
    import erp_pkg::*;
    point_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;
    assign s_ready = (cnt_reg != 3'd4) && !hold;
    assign wr = s_valid && s_ready;
    assign q_valid = (cnt_reg != 3'd0);
    assign rd = q_valid && q_ready;
    assign q_pt = mem_reg[rp_reg];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) begin
                mem_reg[wp_reg] <= s_pt;
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/erp_back.sv =====
// Back end: row products, rounding, saturation and output register.
`default_nettype none
module erp_back #(
    parameter int FRAC_BITS = erp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    output logic                        q_ready,
    input  wire erp_pkg::point_t        q_pt,
    input  wire logic signed [FRAC_BITS+1:0] m_ent [9],
    output logic                        busy,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [31:0]          m_x_out,
    output logic signed [31:0]          m_y_out,
    output logic signed [31:0]          m_z_out,
    output logic                        m_saturated
);
    import erp_pkg::*;
    localparam int EW = FRAC_BITS + 2;
    localparam int PW = EW + 32;
    localparam int AW = PW + 2;

    logic v1_reg, v2_reg;
    logic signed [PW-1:0] p_reg [9];
    logic signed [AW-1:0] acc [3];
    logic signed [31:0] r [3];
    logic sf [3];
    logic adv;
    logic signed [31:0] c [3];

    assign adv = !m_valid || m_ready;
    assign q_ready = adv;
    assign busy = v1_reg || v2_reg || m_valid;
    assign c[0] = q_pt.x; assign c[1] = q_pt.y; assign c[2] = q_pt.z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = AW'(p_reg[3*i]) + AW'(p_reg[3*i+1]) + AW'(p_reg[3*i+2])
                   + (AW'(1) <<< (FRAC_BITS - 1));
            acc[i] = acc[i] >>> FRAC_BITS;
            sf[i] = 1'b0;
            if (acc[i] > AW'(32'sh7FFFFFFF)) begin
                r[i] = 32'sh7FFFFFFF; sf[i] = 1'b1;
            end else if (acc[i] < -(AW'(1) <<< 31)) begin
                r[i] = 32'sh80000000; sf[i] = 1'b1;
            end else begin
                r[i] = acc[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; m_valid <= 1'b0; v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= q_valid;
            m_valid <= v1_reg;
            v2_reg <= 1'b0;
        end
        if (adv) begin
            for (int k = 0; k < 9; k++)
                p_reg[k] <= PW'(m_ent[k]) * PW'(c[k % 3]);
            m_x_out <= r[0];
            m_y_out <= r[1];
            m_z_out <= r[2];
            m_saturated <= sf[0] | sf[1] | sf[2];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/euler_rotate_point_top.sv =====
// Top level of the Euler-angle point rotator.
// Usage: write angles and mode over the APB port while idle; stream signed
// Q16.16 points on s_valid/s_ready; rotated, saturated points leave on
// m_valid/m_ready, one request per point.
// Throughput: one point per cycle once the matrix is built and while the
// receiver takes results. A point moves from the queue to the product register,
// then to the output register. After reset or any register write the first
// point holds the input for a matrix rebuild: each angle in turn in the shared
// CORDIC, then the two-angle or three-angle entry products in the single shared
// multiplier. Reset loads the identity matrix, clears the queue and the output
// stage. When the receiver stalls the output register holds, the datapath
// freezes and the four-entry queue fills before s_ready drops.
`default_nettype none
module euler_rotate_point_top #(
    parameter int CORDIC_STEPS = erp_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = erp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [erp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [31:0]          s_x_in,
    input  wire logic signed [31:0]          s_y_in,
    input  wire logic signed [31:0]          s_z_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [31:0]               m_x_out,
    output logic signed [31:0]               m_y_out,
    output logic signed [31:0]               m_z_out,
    output logic                             m_saturated
);
    import erp_pkg::*;
    logic [15:0] alpha_reg, theta_reg, gamma_reg;
    logic mode_reg, current_reg, wr_en;
    logic mb_busy, mb_done, mb_start, hold;
    logic signed [FRAC_BITS+1:0] ent [9];
    point_t s_pt, q_pt;
    logic q_valid, q_ready, back_busy;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    always_comb begin
        case (paddr)
            REG_ALPHA: prdata = {16'd0, alpha_reg};
            REG_THETA: prdata = {16'd0, theta_reg};
            REG_GAMMA: prdata = {16'd0, gamma_reg};
            REG_MODE:  prdata = {31'd0, mode_reg};
            default:   prdata = '0;
        endcase
    end

    assign mb_start = s_valid && !current_reg && !mb_busy && !back_busy && !q_valid;
    assign hold = !current_reg || mb_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '0; theta_reg <= '0; gamma_reg <= '0;
            mode_reg <= 1'b1; current_reg <= 1'b0;
        end else begin
            if (mb_done) current_reg <= 1'b1;
            if (wr_en) begin
                case (paddr)
                    REG_ALPHA: begin alpha_reg <= pwdata[15:0]; current_reg <= 1'b0; end
                    REG_THETA: begin theta_reg <= pwdata[15:0]; current_reg <= 1'b0; end
                    REG_GAMMA: begin gamma_reg <= pwdata[15:0]; current_reg <= 1'b0; end
                    REG_MODE:  begin mode_reg <= pwdata[0]; current_reg <= 1'b0; end
                    default: ;
                endcase
            end
        end
    end

    assign s_pt = '{x: s_x_in, y: s_y_in, z: s_z_in};

    erp_matrix #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_matrix (
        .aclk(aclk), .aresetn(aresetn), .start(mb_start),
        .alpha(alpha_reg), .theta(theta_reg), .gamma(gamma_reg),
        .use_gamma(mode_reg), .busy(mb_busy), .done(mb_done), .m_ent(ent)
    );

    erp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .hold(hold),
        .s_valid(s_valid), .s_ready(s_ready), .s_pt(s_pt),
        .q_valid(q_valid), .q_ready(q_ready), .q_pt(q_pt)
    );

    erp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_pt(q_pt), .m_ent(ent),
        .busy(back_busy), .m_valid(m_valid), .m_ready(m_ready),
        .m_x_out(m_x_out), .m_y_out(m_y_out), .m_z_out(m_z_out),
        .m_saturated(m_saturated)
    );
endmodule
`default_nettype wire

// ===== dv/euler_rotate_point_top_test.sv =====
// Testbench for the Euler-angle point rotator: table-driven and random points vs a predictor.
`default_nettype none
module euler_rotate_point_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import erp_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    typedef enum int {CYC_NONE, CYC_SEND, CYC_RECV, CYC_BOTH} idle_mode_e;

    typedef struct {
        logic signed [31:0] x, y, z;
    } point_row_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic               sat;
    } rotated_t;

    typedef struct {
        point_row_t pt;
        logic       known;
        rotated_t   res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_x_in = '0, s_y_in = '0, s_z_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_x_out, m_y_out, m_z_out;
    logic m_saturated;

    euler_rotate_point_top dut (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [15:0] cfg_alpha, cfg_theta, cfg_gamma;
    logic        cfg_mode;
    longint      mat[9];
    bit          mat_current;

    rotated_t expected_q[$];
    int errors = 0;
    int points_sent = 0, points_seen = 0, sat_seen = 0;
    idle_mode_e idle_mode = CYC_NONE;
    bit hold_recv = 1'b0;
    longint cycles = 0;

    longint atan_tab[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

    localparam logic [15:0] ANG_SET [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                            16'hFFFF, 16'h2000};

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shift(a * b, FB);
    endfunction

    task automatic sin_cos(input logic [15:0] ang, output longint s, output longint c);
        logic [15:0] a;
        bit flip;
        longint x, y, z, t;
        a = ang;
        flip = 1'b0;
        x = 64'h26DD3B6A;
        y = 0;
        if (((a + 16'h4000) & 16'h8000) != 0) begin
            a = a + 16'h8000;
            flip = 1'b1;
        end
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            t = x;
            if (z >= 0) begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z -= atan_tab[i];
            end else begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = rnd_shift(x, 30 - FB);
        s = rnd_shift(y, 30 - FB);
    endtask

    task automatic rebuild_matrix();
        longint s0, c0, s1, c1, s2, c2, lim;
        longint m[9];
        sin_cos(cfg_alpha, s0, c0);
        sin_cos(cfg_theta, s1, c1);
        if (cfg_mode) begin
            sin_cos(cfg_gamma, s2, c2);
            m[0] = qmul(c2, c0);
            m[1] = -qmul(s2, c0);
            m[2] = s0;
            m[3] = qmul(qmul(s1, s0), c2) + qmul(s2, c1);
            m[4] = qmul(c1, c2) - qmul(qmul(s1, s2), s0);
            m[5] = -qmul(s1, c0);
            m[6] = qmul(s1, s2) - qmul(qmul(s0, c1), c2);
            m[7] = qmul(s1, c2) + qmul(qmul(s2, s0), c1);
            m[8] = qmul(c1, c0);
        end else begin
            m[0] = c0;
            m[1] = qmul(s0, s1);
            m[2] = qmul(s0, c1);
            m[3] = 0;
            m[4] = c1;
            m[5] = -s1;
            m[6] = -s0;
            m[7] = qmul(s1, c0);
            m[8] = qmul(c0, c1);
        end
        lim = longint'(1) <<< (FB + 1);
        for (int k = 0; k < 9; k++)
            mat[k] = (m[k] > lim - 1) ? lim - 1 : (m[k] < -lim) ? -lim : m[k];
        mat_current = 1'b1;
    endtask

    task automatic rotate_point(input point_row_t p, output rotated_t r);
        longint v[3], acc, q;
        logic signed [31:0] o[3];
        v[0] = p.x;
        v[1] = p.y;
        v[2] = p.z;
        if (!mat_current)
            rebuild_matrix();
        r.sat = 1'b0;
        for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += mat[row * 3 + j] * v[j];
            q = rnd_shift(acc, FB);
            if (q > 64'sd2147483647) begin
                q = 64'sd2147483647;
                r.sat = 1'b1;
            end else if (q < -64'sd2147483648) begin
                q = -64'sd2147483648;
                r.sat = 1'b1;
            end
            o[row] = q[31:0];
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, points_seen);
    endtask

    // receiver: stall pattern, optional long hold-off, result checking
    always @(posedge aclk) begin
        rotated_t e;
        if (aresetn) begin
            cycles++;
            if (m_valid && m_ready) begin
                points_seen++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("MISMATCH unexpected result %h %h %h", m_x_out, m_y_out, m_z_out);
                end else begin
                    e = expected_q.pop_front();
                    if (m_x_out !== e.x) report_mismatch("x_out", m_x_out, e.x);
                    if (m_y_out !== e.y) report_mismatch("y_out", m_y_out, e.y);
                    if (m_z_out !== e.z) report_mismatch("z_out", m_z_out, e.z);
                    if (m_saturated !== e.sat)
                        report_mismatch("saturated", m_saturated, e.sat);
                    if (m_saturated) sat_seen++;
                end
            end
            if (hold_recv)
                m_ready <= 1'b0;
            else if (idle_mode == CYC_RECV || idle_mode == CYC_BOTH)
                m_ready <= ($urandom_range(99) >= 66);
            else
                m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("euler_rotate_point_top_test NOT OK");
            $finish;
        end
    end

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_ALPHA: cfg_alpha = val[15:0];
            REG_THETA: cfg_theta = val[15:0];
            REG_GAMMA: cfg_gamma = val[15:0];
            REG_MODE:  cfg_mode = val[0];
            default: ;
        endcase
        mat_current = 1'b0;
    endtask

    task automatic set_angles(input logic [15:0] a, input logic [15:0] t,
                              input logic [15:0] g, input logic m);
        reg_write(REG_ALPHA, ($urandom() & 32'hFFFF0000) | {16'h0, a});
        reg_write(REG_THETA, ($urandom() & 32'hFFFF0000) | {16'h0, t});
        reg_write(REG_GAMMA, {16'h0, g});
        reg_write(REG_MODE, ($urandom() & 32'hFFFFFFFE) | {31'h0, m});
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_point(input point_row_t p, input bit known, input rotated_t want);
        rotated_t r;
        if (idle_mode == CYC_SEND || idle_mode == CYC_BOTH)
            while ($urandom_range(99) < 66) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_x_in <= p.x;
        s_y_in <= p.y;
        s_z_in <= p.z;
        do @(posedge aclk); while (!s_ready);
        rotate_point(p, r);
        if (known && (r.x !== want.x || r.y !== want.y || r.z !== want.z || r.sat !== want.sat))
            report_mismatch("table row vs predictor", r.x, want.x);
        expected_q.push_back(r);
        points_sent++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return $signed($urandom_range(2097152)) - 32'sd1048576;
            default: return $signed($urandom_range(33554432)) - 32'sd16777216;
        endcase
    endfunction

    localparam logic signed [31:0] ONE = 32'sh00010000;
    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    stim_row_t table_rows[] = '{
        '{'{ONE, 32'sh2, -ONE}, 1'b0, '{ONE, 32'sh2, -ONE, 1'b0}},
        '{'{PMAX, PMIN, 32'sh0}, 1'b0, '{PMAX, PMIN, 32'sh0, 1'b0}},
        '{'{32'sh0, 32'sh0, 32'sh0}, 1'b1, '{32'sh0, 32'sh0, 32'sh0, 1'b0}},
        '{'{-32'sh1, PMAX, PMIN}, 1'b0, '{-32'sh1, PMAX, PMIN, 1'b0}}
    };

    initial begin
        point_row_t p;
        rotated_t dummy;
        cfg_alpha = 0; cfg_theta = 0; cfg_gamma = 0; cfg_mode = 1'b1;
        for (int k = 0; k < 9; k++) mat[k] = (k % 4 == 0) ? (longint'(1) <<< FB) : 0;
        mat_current = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // first points after reset, zero point and extremes
        foreach (table_rows[i])
            send_point(table_rows[i].pt, table_rows[i].known, table_rows[i].res);
        wait_drained();

        // directed: quarter turns, extremes, both modes, gamma write in two-angle mode
        for (int k = 0; k < 6; k++) begin
            set_angles(ANG_SET[k], ANG_SET[(k + 2) % 6], ANG_SET[(k + 4) % 6], k[0]);
            p = '{PMAX, PMIN, ONE};
            send_point(p, 1'b0, dummy);
            p = '{-ONE, ONE <<< 4, PMIN};
            send_point(p, 1'b0, dummy);
            wait_drained();
        end
        reg_write(REG_MODE, 32'h0);
        reg_write(REG_GAMMA, 32'h1234);
        p = '{ONE, ONE, ONE};
        send_point(p, 1'b0, dummy);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            idle_mode = idle_mode_e'(ph % 4);
            if ($urandom_range(3) == 0)
                set_angles($urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom()),
                           16'($urandom()), ph[1]);
            else
                set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           1'($urandom_range(1)));
            if (ph == 5) begin
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (200) @(posedge aclk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 150; n++) begin
                p = '{rand_coord(), rand_coord(), rand_coord()};
                send_point(p, 1'b0, dummy);
            end
            wait_drained();
        end

        idle_mode = CYC_NONE;
        wait_drained();
        $display("%0d points rotated over directed and random angle settings, %0d saturated.",
                 points_seen, sat_seen);
        $display("Both modes, quarter-turn angles, saturation and backpressure were covered.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("euler_rotate_point_top_test OK");
        end else begin
            $display("euler_rotate_point_top_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
